@@ rtl/mte_pkg.sv @@
package mte_pkg;

  // Morse pattern: first element in bit 4, 1 = dash, 0 = dot.
  typedef struct packed {
    logic [2:0] len;
    logic [4:0] pat;
  } code_t;

  typedef struct packed {
    logic       is_char;
    logic [5:0] idx;
  } char_class_t;

  localparam code_t AR_CODE = '{len: 3'd5, pat: 5'b01010};

  function automatic char_class_t classify(input logic [7:0] ch);
    char_class_t c;
    logic [7:0]  up;
    up = ch;
    if (ch inside {[8'h61:8'h7A]}) begin
      up = ch - 8'h20;
    end
    c.is_char = 1'b0;
    c.idx     = '0;
    if (up inside {[8'h41:8'h5A]}) begin
      c.is_char = 1'b1;
      c.idx     = 6'(up - 8'h41);
    end else if (up inside {[8'h30:8'h39]}) begin
      c.is_char = 1'b1;
      c.idx     = 6'(up - 8'h30) + 6'd26;
    end
    return c;
  endfunction

  function automatic code_t lookup(input logic [5:0] idx);
    code_t c;
    case (idx)
      6'd0:  c = '{3'd2, 5'b01000}; // A
      6'd1:  c = '{3'd4, 5'b10000}; // B
      6'd2:  c = '{3'd4, 5'b10100}; // C
      6'd3:  c = '{3'd3, 5'b10000}; // D
      6'd4:  c = '{3'd1, 5'b00000}; // E
      6'd5:  c = '{3'd4, 5'b00100}; // F
      6'd6:  c = '{3'd3, 5'b11000}; // G
      6'd7:  c = '{3'd4, 5'b00000}; // H
      6'd8:  c = '{3'd2, 5'b00000}; // I
      6'd9:  c = '{3'd4, 5'b01110}; // J
      6'd10: c = '{3'd3, 5'b10100}; // K
      6'd11: c = '{3'd4, 5'b01000}; // L
      6'd12: c = '{3'd2, 5'b11000}; // M
      6'd13: c = '{3'd2, 5'b10000}; // N
      6'd14: c = '{3'd3, 5'b11100}; // O
      6'd15: c = '{3'd4, 5'b01100}; // P
      6'd16: c = '{3'd4, 5'b11010}; // Q
      6'd17: c = '{3'd3, 5'b01000}; // R
      6'd18: c = '{3'd3, 5'b00000}; // S
      6'd19: c = '{3'd1, 5'b10000}; // T
      6'd20: c = '{3'd3, 5'b00100}; // U
      6'd21: c = '{3'd4, 5'b00010}; // V
      6'd22: c = '{3'd3, 5'b01100}; // W
      6'd23: c = '{3'd4, 5'b10010}; // X
      6'd24: c = '{3'd4, 5'b10110}; // Y
      6'd25: c = '{3'd4, 5'b11000}; // Z
      6'd26: c = '{3'd5, 5'b11111}; // 0
      6'd27: c = '{3'd5, 5'b01111}; // 1
      6'd28: c = '{3'd5, 5'b00111}; // 2
      6'd29: c = '{3'd5, 5'b00011}; // 3
      6'd30: c = '{3'd5, 5'b00001}; // 4
      6'd31: c = '{3'd5, 5'b00000}; // 5
      6'd32: c = '{3'd5, 5'b10000}; // 6
      6'd33: c = '{3'd5, 5'b11000}; // 7
      6'd34: c = '{3'd5, 5'b11100}; // 8
      6'd35: c = '{3'd5, 5'b11110}; // 9
      default: c = '{3'd1, 5'b00000};
    endcase
    return c;
  endfunction

endpackage

@@ rtl/morse_text_encoder_core.sv @@
// Morse text encoder: ASCII text in, packed International Morse bitstream out.
//
// Input channel (in_*): one text byte per beat, with in_end_of_text on the
// last byte of a message. Letters (either case) and digits are encoded;
// every other byte is a separator. A separator run between characters turns
// into a seven-zero word gap; leading and trailing runs vanish. The beat
// with in_end_of_text appends the AR prosign and flushes the final byte.
//
// Output channel (out_*): one code byte per beat, MSB first. out_valid_bits
// is 8 except on a zero-padded final byte; out_message_end marks the last.
//
// Timing: a single bit-insertion shifter places one run of up to four bits
// per cycle unless a byte waits on the output (one Morse element with its
// trailing zero, or a gap), stepped by a small sequencer. A character is
// accepted, then takes a word-gap step if due, a step per element and a
// closing gap step, in_stall high after the accept. end_of_text on any byte
// adds AR steps and a flush step unless AR ends on a byte boundary.
// One output register parts the channels; while out_stall holds it full,
// any step that would produce a byte waits.
// Reset (rst_n low, synchronous) drops any partial message and the output.
module morse_text_encoder_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_text_byte,
  input  logic       in_end_of_text,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_code_byte,
  output logic [3:0] out_valid_bits,
  output logic       out_message_end
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PRE,
    S_ELEM,
    S_POST,
    S_AR,
    S_FLUSH
  } state_t;

  state_t      state_r, state_nxt;
  logic [7:0]  partial_r, partial_nxt;
  logic [2:0]  fill_r, fill_nxt;
  logic        seen_r, seen_nxt;
  logic        gap_r, gap_nxt;
  logic        end_r, end_nxt;
  logic [4:0]  pat_r, pat_nxt;
  logic [2:0]  rem_r, rem_nxt;
  logic        ov_r, ov_nxt;
  logic [7:0]  ocode_r, ocode_nxt;
  logic [3:0]  ovb_r, ovb_nxt;
  logic        oend_r, oend_nxt;

  logic [3:0]  chunk;
  logic [2:0]  chunk_len;
  logic [11:0] win;
  logic [3:0]  total;
  logic        out_free;
  logic        needs_out;
  logic        go;
  logic        accept;
  mte_pkg::char_class_t cls;
  mte_pkg::code_t       code;

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = ov_r;
  assign out_code_byte   = ocode_r;
  assign out_valid_bits  = ovb_r;
  assign out_message_end = oend_r;

  assign accept   = in_valid && !in_stall;
  assign cls      = mte_pkg::classify(in_text_byte);
  assign code     = mte_pkg::lookup(cls.idx);
  assign out_free = !ov_r || !out_stall;

  // Pick the run of bits for this step: dash+gap, dot+gap, bare dot or zeros.
  always_comb begin
    chunk     = 4'b0000;
    chunk_len = 3'd4;
    case (state_r)
      S_PRE: begin
        chunk_len = 3'd4;
      end
      S_ELEM: begin
        chunk     = pat_r[4] ? 4'b1110 : 4'b1000;
        chunk_len = pat_r[4] ? 3'd4 : 3'd2;
      end
      S_POST: begin
        chunk_len = 3'd2;
      end
      S_AR: begin
        chunk = pat_r[4] ? 4'b1110 : 4'b1000;
        if (pat_r[4]) begin
          chunk_len = 3'd4;
        end else begin
          chunk_len = (rem_r == 3'd1) ? 3'd1 : 3'd2;
        end
      end
      default: begin
        chunk_len = 3'd4;
      end
    endcase
  end

  // Shared shifter: merge the run behind the collected bits.
  assign win   = {partial_r, 4'b0000} | ({chunk, 8'h00} >> fill_r);
  assign total = {1'b0, fill_r} + {1'b0, chunk_len};

  always_comb begin
    needs_out = 1'b0;
    case (state_r)
      S_PRE, S_ELEM, S_POST, S_AR: needs_out = total[3];
      S_FLUSH:                     needs_out = 1'b1;
      default:                     needs_out = 1'b0;
    endcase
  end
  assign go = !needs_out || out_free;

  always_comb begin
    state_nxt   = state_r;
    partial_nxt = partial_r;
    fill_nxt    = fill_r;
    seen_nxt    = seen_r;
    gap_nxt     = gap_r;
    end_nxt     = end_r;
    pat_nxt     = pat_r;
    rem_nxt     = rem_r;
    ov_nxt      = ov_r && out_stall;
    ocode_nxt   = ocode_r;
    ovb_nxt     = ovb_r;
    oend_nxt    = oend_r;

    if (state_r != S_IDLE && state_r != S_FLUSH && go) begin
      // Commit the run; spill a full byte to the output register.
      if (total[3]) begin
        ov_nxt      = 1'b1;
        ocode_nxt   = win[11:4];
        ovb_nxt     = 4'd8;
        oend_nxt    = (state_r == S_AR) && (rem_r == 3'd1);
        partial_nxt = {win[3:0], 4'b0000};
      end else begin
        partial_nxt = win[11:4];
      end
      fill_nxt = total[2:0];
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          end_nxt = in_end_of_text;
          pat_nxt = code.pat;
          rem_nxt = code.len;
          if (cls.is_char) begin
            state_nxt = (gap_r && seen_r) ? S_PRE : S_ELEM;
            seen_nxt  = 1'b1;
            gap_nxt   = 1'b0;
          end else begin
            if (seen_r) begin
              gap_nxt = 1'b1;
            end
            if (in_end_of_text) begin
              state_nxt = S_AR;
              pat_nxt   = mte_pkg::AR_CODE.pat;
              rem_nxt   = mte_pkg::AR_CODE.len;
            end
          end
        end
      end
      S_PRE: begin
        if (go) begin
          state_nxt = S_ELEM;
        end
      end
      S_ELEM: begin
        if (go) begin
          pat_nxt = {pat_r[3:0], 1'b0};
          rem_nxt = rem_r - 3'd1;
          if (rem_r == 3'd1) begin
            state_nxt = S_POST;
          end
        end
      end
      S_POST: begin
        if (go) begin
          if (end_r) begin
            state_nxt = S_AR;
            pat_nxt   = mte_pkg::AR_CODE.pat;
            rem_nxt   = mte_pkg::AR_CODE.len;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_AR: begin
        if (go) begin
          pat_nxt = {pat_r[3:0], 1'b0};
          rem_nxt = rem_r - 3'd1;
          if (rem_r == 3'd1) begin
            if (total[3]) begin
              // AR closed a full byte: it already carries the end mark.
              state_nxt = S_IDLE;
              seen_nxt  = 1'b0;
              gap_nxt   = 1'b0;
            end else begin
              state_nxt = S_FLUSH;
            end
          end
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          ov_nxt      = 1'b1;
          ocode_nxt   = partial_r;
          ovb_nxt     = {1'b0, fill_r};
          oend_nxt    = 1'b1;
          partial_nxt = '0;
          fill_nxt    = '0;
          seen_nxt    = 1'b0;
          gap_nxt     = 1'b0;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      partial_r <= '0;
      fill_r    <= '0;
      seen_r    <= 1'b0;
      gap_r     <= 1'b0;
      end_r     <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      partial_r <= partial_nxt;
      fill_r    <= fill_nxt;
      seen_r    <= seen_nxt;
      gap_r     <= gap_nxt;
      end_r     <= end_nxt;
      ov_r      <= ov_nxt;
    end
    pat_r   <= pat_nxt;
    rem_r   <= rem_nxt;
    ocode_r <= ocode_nxt;
    ovb_r   <= ovb_nxt;
    oend_r  <= oend_nxt;
  end

endmodule

@@ rtl/mte_checker.sv @@
module mte_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] in_text_byte,
  input logic       in_end_of_text,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_code_byte,
  input logic [3:0] out_valid_bits,
  input logic       out_message_end
);

  // A stalled beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_code_byte)
      && $stable(out_valid_bits) && $stable(out_message_end))
    else $error("output beat changed under stall");

  // Only the final byte of a message may be short.
  a_short_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_message_end |-> out_valid_bits == 4'd8)
    else $error("short byte before message end");

  a_bits_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_valid_bits != 4'd0 && out_valid_bits <= 4'd8)
    else $error("valid_bits out of range");

  // Padding past the meaningful bits is zero.
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_code_byte & (8'hFF >> out_valid_bits)) == 8'h00)
    else $error("nonzero padding bits");

  // End of text always produces AR, so the input side goes busy.
  a_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_end_of_text |=> in_stall)
    else $error("end of text accepted without AR work");

endmodule

bind morse_text_encoder_core mte_checker u_mte_checker (.*);
